[rtl/core/paged_object_pool_allocator_unit_macros.svh]
// assertion macros for the paged object pool allocator
// used by modules that check their own logic; empty bodies under synthesis
`ifndef PAGED_OBJECT_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define PAGED_OBJECT_POOL_ALLOCATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define POPA_ASSERT(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("popa assertion failed");
`define POPA_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("popa assertion failed");
`else
`define POPA_ASSERT(name, prop)
`define POPA_ASSERT_NEXT(name, pre, post)
`endif

`endif

[rtl/core/popa_pkg.sv]
// shared types and constants of the paged object pool allocator
// no dependencies
`default_nettype none

package popa_pkg;

    localparam int DEF_MAX_PAGES            = 16;
    localparam int DEF_MAX_OBJECTS_PER_PAGE = 64;
    localparam int DEF_ADDRESS_BITS         = 20;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OBJECTS_PER_PAGE = 3'd0,
        CFG_PAGE_LIMIT       = 3'd1,
        CFG_DEBUG_ON         = 3'd2,
        CFG_FIRST_OFFSET     = 3'd3,
        CFG_BLOCK_STRIDE     = 3'd4,
        CFG_PAGE_BYTES       = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_PAGES     = 2'd1,
        ST_BAD_BOUNDARY = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;
    localparam logic MARK_SET  = 1'b1;

    typedef struct packed {
        logic [6:0]  objects_per_page;
        logic [4:0]  page_limit;
        logic        debug_on;
        logic [11:0] first_offset;
        logic [11:0] block_stride;
        logic [15:0] page_bytes;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        objects_per_page: 7'd4,
        page_limit:       5'd0,
        debug_on:         1'b1,
        first_offset:     12'd8,
        block_stride:     12'd8,
        page_bytes:       16'd40
    };

endpackage

`default_nettype wire

[rtl/core/popa_front.sv]
// request queue of the allocator: accepts and classifies incoming words
// depends on popa_pkg
`default_nettype none

module popa_front
    import popa_pkg::*;
#(
    parameter int ADDRESS_BITS = DEF_ADDRESS_BITS
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic                    i_action,
    input  wire logic [ADDRESS_BITS-1:0] i_obj_address,
    input  wire logic                    i_hold,
    output logic                         o_req_valid,
    output logic                         o_req_free,
    output logic [ADDRESS_BITS-1:0]      o_req_addr,
    input  wire logic                    i_req_take
);

    logic                    r_is_free [2];
    logic [ADDRESS_BITS-1:0] r_addr    [2];
    logic                    r_wp;
    logic                    r_rp;
    logic [1:0]              r_cnt;
    logic                    accept;
    logic                    take;

    assign full        = (r_cnt == 2'd2) || i_hold;
    assign accept      = push && !full;
    assign o_req_valid = (r_cnt != 2'd0);
    assign take        = i_req_take && o_req_valid;
    assign o_req_free  = r_is_free[r_rp];
    assign o_req_addr  = r_addr[r_rp];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_free[r_wp] <= (i_action == ACT_FREE);
            r_addr[r_wp]    <= i_obj_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= !r_wp;
            end
            if (take) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, accept} - {1'b0, take};
        end
    end

endmodule

`default_nettype wire

[rtl/core/popa_div.sv]
// restoring divider, one quotient bit per cycle
// depends on popa_pkg
`default_nettype none

module popa_div
    import popa_pkg::*;
#(
    parameter int DW = 20
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [15:0]   i_divisor,
    output logic               o_done,
    output logic [DW-1:0]      o_quot,
    output logic [15:0]        o_rem
);

    localparam int CNTW = $clog2(DW);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_quot;
    logic [15:0]     r_rem;
    logic [15:0]     r_div;
    logic [16:0]     trial;
    logic            fits;

    assign trial  = {r_rem, r_quot[DW-1]};
    assign fits   = (trial >= {1'b0, r_div});
    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= 16'd0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DW-2:0], fits};
            r_rem  <= fits ? 16'(trial - {1'b0, r_div}) : trial[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNTW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/popa_back.sv]
// execution engine: free list, in-use marks, page grants and address checks
// depends on popa_pkg, popa_div and the assertion macro header
`default_nettype none
`include "paged_object_pool_allocator_unit_macros.svh"

module popa_back
    import popa_pkg::*;
#(
    parameter int MAX_PAGES            = DEF_MAX_PAGES,
    parameter int MAX_OBJECTS_PER_PAGE = DEF_MAX_OBJECTS_PER_PAGE,
    parameter int ADDRESS_BITS         = DEF_ADDRESS_BITS,
    localparam int CW  = $clog2(MAX_PAGES * MAX_OBJECTS_PER_PAGE + 1),
    localparam int PCW = $clog2(MAX_PAGES + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cfg                    i_cfg,
    input  wire logic                    i_req_valid,
    input  wire logic                    i_req_free,
    input  wire logic [ADDRESS_BITS-1:0] i_req_addr,
    output logic                         o_req_take,
    output logic                         o_clearing,
    output logic                         o_res_valid,
    input  wire logic                    i_res_ready,
    output t_status                      o_status,
    output logic [ADDRESS_BITS-1:0]      o_granted_address,
    output logic [31:0]                  o_alloc_number,
    output logic [CW-1:0]                o_objects_in_use,
    output logic [CW-1:0]                o_free_objects,
    output logic [CW-1:0]                o_most_objects,
    output logic [PCW-1:0]               o_pages_granted,
    output logic [31:0]                  o_free_count_total
);

    localparam int AW    = ADDRESS_BITS;
    localparam int POOL  = MAX_PAGES * MAX_OBJECTS_PER_PAGE;
    localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SW    = (MAX_OBJECTS_PER_PAGE > 1) ? $clog2(MAX_OBJECTS_PER_PAGE) : 1;
    localparam int IW    = PW + SW;
    localparam int DEPTH = 1 << IW;
    localparam int NW    = SW + 1;
    localparam int DW    = (AW > 16) ? AW : 16;
    localparam int P1W   = 16 + PW;
    localparam int P2W   = 12 + SW;
    localparam int SUM_W = ((P1W > P2W) ? P1W : P2W) + 2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_GRANT,
        S_POP_RD,
        S_POP,
        S_POP_SUM,
        S_FDIV1,
        S_FDIV2,
        S_FMARK_RD,
        S_FMARK,
        S_RESULT
    } t_state;

    t_state          r_state;
    logic [IW:0]     r_head;
    logic [PCW-1:0]  r_pages;
    logic [31:0]     r_alloc_tot;
    logic [31:0]     r_free_tot;
    logic [CW-1:0]   r_in_use;
    logic [CW-1:0]   r_peak;
    logic [CW-1:0]   r_free_cnt;
    logic [SW-1:0]   r_cnt;
    logic [IW-1:0]   r_clr;
    logic [IW-1:0]   r_idx;
    t_status         r_status;
    logic [AW-1:0]   r_granted;
    logic [P1W-1:0]  r_p1;
    logic [P2W-1:0]  r_p2;

    logic [IW:0]     link_mem [DEPTH];
    logic            mark_mem [DEPTH];
    logic [IW:0]     r_link_q;
    logic            r_mark_q;

    logic            link_we;
    logic [IW-1:0]   link_waddr;
    logic [IW:0]     link_wdata;
    logic [IW-1:0]   link_raddr;
    logic            mark_we;
    logic [IW-1:0]   mark_waddr;
    logic            mark_wdata;
    logic [IW-1:0]   mark_raddr;

    logic            div_start;
    logic [DW-1:0]   div_dividend;
    logic [15:0]     div_divisor;
    logic            div_done;
    logic [DW-1:0]   div_quot;
    logic [15:0]     div_rem;

    logic [NW-1:0]   n_eff;
    logic [PCW-1:0]  lim;
    logic [PW-1:0]   pg;
    logic [15:0]     off2;
    logic [SUM_W-1:0]    sum;
    logic [SUM_W+AW-1:0] sum_ext;
    logic [CW-1:0]   n_in_use;

    assign pg       = r_pages[PW-1:0];
    assign off2     = div_rem - 16'(i_cfg.first_offset);
    assign sum      = SUM_W'(r_p1) + SUM_W'(i_cfg.first_offset) + SUM_W'(r_p2);
    assign sum_ext  = {AW'(0), sum};
    assign n_in_use = r_in_use + 1'b1;

    always_comb begin
        if (i_cfg.objects_per_page == 7'd0) begin
            n_eff = NW'(1);
        end else if (int'(i_cfg.objects_per_page) > MAX_OBJECTS_PER_PAGE) begin
            n_eff = NW'(MAX_OBJECTS_PER_PAGE);
        end else begin
            n_eff = NW'(i_cfg.objects_per_page);
        end
        if (i_cfg.page_limit == 5'd0 || int'(i_cfg.page_limit) > MAX_PAGES) begin
            lim = PCW'(MAX_PAGES);
        end else begin
            lim = PCW'(i_cfg.page_limit);
        end
    end

    assign o_req_take  = (r_state == S_IDLE) && i_req_valid;
    assign o_clearing  = (r_state == S_CLEAR);
    assign o_res_valid = (r_state == S_RESULT);

    always_comb begin
        link_we      = 1'b0;
        link_waddr   = '0;
        link_wdata   = '0;
        link_raddr   = r_head[IW-1:0];
        mark_we      = 1'b0;
        mark_waddr   = r_idx;
        mark_wdata   = 1'b0;
        mark_raddr   = r_idx;
        div_start    = 1'b0;
        div_dividend = DW'(i_req_addr);
        div_divisor  = i_cfg.page_bytes;
        case (r_state)
            S_CLEAR: begin
                mark_we    = 1'b1;
                mark_waddr = r_clr;
            end
            S_IDLE: begin
                if (i_req_valid && i_req_free && i_cfg.page_bytes != 16'd0) begin
                    div_start = 1'b1;
                end
            end
            S_GRANT: begin
                link_we    = 1'b1;
                link_waddr = {pg, r_cnt};
                link_wdata = (r_cnt == '0) ? r_head : {1'b0, pg, SW'(r_cnt - 1'b1)};
            end
            S_POP: begin
                mark_we    = 1'b1;
                mark_waddr = r_head[IW-1:0];
                mark_wdata = MARK_SET;
            end
            S_FDIV1: begin
                div_dividend = DW'(off2);
                div_divisor  = 16'(i_cfg.block_stride);
                if (div_done && div_quot < DW'(r_pages) &&
                    div_rem >= 16'(i_cfg.first_offset) && i_cfg.block_stride != 12'd0) begin
                    div_start = 1'b1;
                end
            end
            S_FMARK: begin
                if (r_mark_q == MARK_SET) begin
                    mark_we    = 1'b1;
                    link_we    = 1'b1;
                    link_waddr = r_idx;
                    link_wdata = r_head;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        r_link_q <= link_mem[link_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (mark_we) begin
            mark_mem[mark_waddr] <= mark_wdata;
        end
        r_mark_q <= mark_mem[mark_raddr];
    end

    popa_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_head      <= {1'b1, IW'(0)};
            r_pages     <= '0;
            r_alloc_tot <= '0;
            r_free_tot  <= '0;
            r_in_use    <= '0;
            r_peak      <= '0;
            r_free_cnt  <= '0;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_status    <= ST_OK;
            r_granted   <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_status  <= ST_OK;
                        r_granted <= '0;
                        r_cnt     <= '0;
                        if (!i_req_free) begin
                            if (!r_head[IW]) begin
                                r_state <= S_POP_RD;
                            end else if (r_pages >= lim) begin
                                r_status <= ST_NO_PAGES;
                                r_state  <= S_RESULT;
                            end else begin
                                r_state <= S_GRANT;
                            end
                        end else if (i_cfg.page_bytes == 16'd0) begin
                            r_status <= i_cfg.debug_on ? ST_BAD_BOUNDARY : ST_OK;
                            r_state  <= S_RESULT;
                        end else begin
                            r_state <= S_FDIV1;
                        end
                    end
                end
                S_GRANT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if ({1'b0, r_cnt} == n_eff - 1'b1) begin
                        r_head     <= {1'b0, pg, r_cnt};
                        r_pages    <= r_pages + 1'b1;
                        r_free_cnt <= r_free_cnt + CW'(n_eff);
                        r_state    <= S_POP_RD;
                    end
                end
                S_POP_RD: begin
                    r_state <= S_POP;
                end
                S_POP: begin
                    r_head      <= r_link_q;
                    r_alloc_tot <= r_alloc_tot + 1'b1;
                    r_in_use    <= n_in_use;
                    if (n_in_use > r_peak) begin
                        r_peak <= n_in_use;
                    end
                    r_free_cnt <= r_free_cnt - 1'b1;
                    r_p1 <= P1W'(r_head[IW-1:SW]) * P1W'(i_cfg.page_bytes);
                    r_p2 <= P2W'(r_head[SW-1:0]) * P2W'(i_cfg.block_stride);
                    r_state <= S_POP_SUM;
                end
                S_POP_SUM: begin
                    r_granted <= sum_ext[AW-1:0];
                    r_state   <= S_RESULT;
                end
                S_FDIV1: begin
                    if (div_done) begin
                        r_idx <= {div_quot[PW-1:0], SW'(0)};
                        if (div_quot >= DW'(r_pages) ||
                            div_rem < 16'(i_cfg.first_offset)) begin
                            r_status <= i_cfg.debug_on ? ST_BAD_BOUNDARY : ST_OK;
                            r_state  <= S_RESULT;
                        end else if (i_cfg.block_stride == 12'd0) begin
                            if (off2 != 16'd0) begin
                                r_status <= i_cfg.debug_on ? ST_BAD_BOUNDARY : ST_OK;
                                r_state  <= S_RESULT;
                            end else begin
                                r_state <= S_FMARK_RD;
                            end
                        end else begin
                            r_state <= S_FDIV2;
                        end
                    end
                end
                S_FDIV2: begin
                    if (div_done) begin
                        if (div_rem != 16'd0 || div_quot >= DW'(n_eff)) begin
                            r_status <= i_cfg.debug_on ? ST_BAD_BOUNDARY : ST_OK;
                            r_state  <= S_RESULT;
                        end else begin
                            r_idx[SW-1:0] <= div_quot[SW-1:0];
                            r_state       <= S_FMARK_RD;
                        end
                    end
                end
                S_FMARK_RD: begin
                    r_state <= S_FMARK;
                end
                S_FMARK: begin
                    if (r_mark_q != MARK_SET) begin
                        r_status <= i_cfg.debug_on ? ST_ALREADY_FREE : ST_OK;
                    end else begin
                        r_head     <= {1'b0, r_idx};
                        r_free_tot <= r_free_tot + 1'b1;
                        r_in_use   <= r_in_use - 1'b1;
                        r_free_cnt <= r_free_cnt + 1'b1;
                    end
                    r_state <= S_RESULT;
                end
                S_RESULT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_status           = r_status;
    assign o_granted_address  = r_granted;
    assign o_alloc_number     = r_alloc_tot;
    assign o_objects_in_use   = r_in_use;
    assign o_free_objects     = r_free_cnt;
    assign o_most_objects     = r_peak;
    assign o_pages_granted    = r_pages;
    assign o_free_count_total = r_free_tot;

    `POPA_ASSERT(a_pool_bound, ({1'b0, r_in_use} + {1'b0, r_free_cnt}) <= (CW+1)'(POOL))
    `POPA_ASSERT(a_peak_covers, r_peak >= r_in_use)
    `POPA_ASSERT(a_page_bound, r_pages <= PCW'(MAX_PAGES))
    `POPA_ASSERT_NEXT(a_result_done, r_state == S_RESULT && i_res_ready, r_state == S_IDLE)
    `POPA_ASSERT_NEXT(a_clear_no_take, r_state == S_CLEAR, !$past(o_req_take))

endmodule

`default_nettype wire

[rtl/core/paged_object_pool_allocator_unit.sv]
// allocate pops the head of the free list; on an empty list a page grant, if the page limit
// allows, first links the new page's objects into it. free: one or two passes of the shared
// serial divider (the second only with a nonzero block stride); one request is worked at a time.
// after reset the in-use marks are cleared, one entry a cycle over the index space,
// and full stays high meanwhile; config is taken always.
`default_nettype none

module paged_object_pool_allocator_unit
    import popa_pkg::*;
#(
    parameter int MAX_PAGES            = DEF_MAX_PAGES,
    parameter int MAX_OBJECTS_PER_PAGE = DEF_MAX_OBJECTS_PER_PAGE,
    parameter int ADDRESS_BITS         = DEF_ADDRESS_BITS,
    localparam int CW  = $clog2(MAX_PAGES * MAX_OBJECTS_PER_PAGE + 1),
    localparam int PCW = $clog2(MAX_PAGES + 1)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic                    i_action,
    input  wire logic [ADDRESS_BITS-1:0] i_obj_address,
    output logic                         empty,
    input  wire logic                    pop,
    output logic [1:0]                   o_status,
    output logic [ADDRESS_BITS-1:0]      o_granted_address,
    output logic [31:0]                  o_alloc_number,
    output logic [CW-1:0]                o_objects_in_use,
    output logic [CW-1:0]                o_free_objects,
    output logic [CW-1:0]                o_most_objects,
    output logic [PCW-1:0]               o_pages_granted,
    output logic [31:0]                  o_free_count_total,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_cfg                    r_cfg;
    logic                    clearing;
    logic                    req_valid;
    logic                    req_free;
    logic [ADDRESS_BITS-1:0] req_addr;
    logic                    req_take;
    logic                    res_valid;
    logic                    res_take;
    t_status                 res_status;
    logic [ADDRESS_BITS-1:0] res_granted;
    logic [31:0]             res_alloc;
    logic [CW-1:0]           res_in_use;
    logic [CW-1:0]           res_free;
    logic [CW-1:0]           res_most;
    logic [PCW-1:0]          res_pages;
    logic [31:0]             res_free_tot;
    logic                    r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OBJECTS_PER_PAGE: r_cfg.objects_per_page <= i_cfg_data[6:0];
                CFG_PAGE_LIMIT:       r_cfg.page_limit       <= i_cfg_data[4:0];
                CFG_DEBUG_ON:         r_cfg.debug_on         <= i_cfg_data[0];
                CFG_FIRST_OFFSET:     r_cfg.first_offset     <= i_cfg_data[11:0];
                CFG_BLOCK_STRIDE:     r_cfg.block_stride     <= i_cfg_data[11:0];
                CFG_PAGE_BYTES:       r_cfg.page_bytes       <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    popa_front #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_action      (i_action),
        .i_obj_address (i_obj_address),
        .i_hold        (clearing),
        .o_req_valid   (req_valid),
        .o_req_free    (req_free),
        .o_req_addr    (req_addr),
        .i_req_take    (req_take)
    );

    popa_back #(
        .MAX_PAGES            (MAX_PAGES),
        .MAX_OBJECTS_PER_PAGE (MAX_OBJECTS_PER_PAGE),
        .ADDRESS_BITS         (ADDRESS_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_req_valid        (req_valid),
        .i_req_free         (req_free),
        .i_req_addr         (req_addr),
        .o_req_take         (req_take),
        .o_clearing         (clearing),
        .o_res_valid        (res_valid),
        .i_res_ready        (res_take),
        .o_status           (res_status),
        .o_granted_address  (res_granted),
        .o_alloc_number     (res_alloc),
        .o_objects_in_use   (res_in_use),
        .o_free_objects     (res_free),
        .o_most_objects     (res_most),
        .o_pages_granted    (res_pages),
        .o_free_count_total (res_free_tot)
    );

    // result word register
    assign empty    = !r_out_valid;
    assign res_take = res_valid && (!r_out_valid || pop);

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            o_status           <= res_status;
            o_granted_address  <= res_granted;
            o_alloc_number     <= res_alloc;
            o_objects_in_use   <= res_in_use;
            o_free_objects     <= res_free;
            o_most_objects     <= res_most;
            o_pages_granted    <= res_pages;
            o_free_count_total <= res_free_tot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire
